// File: hdl/ffgp_pkg.sv
// ----------------------------------------------------------------------------
// ffgp_pkg
// Shared types and constants of the fullest-first group packer: field widths,
// operation and status codes, and the scan token and update command that
// travel along the row of group cells.
// ----------------------------------------------------------------------------
package ffgp_pkg;

    localparam int NUM_GROUPS  = 16;
    localparam int NUM_CLIENTS = 256;
    localparam int GROUP_W     = 4;
    localparam int CLIENT_W    = 8;
    localparam int COUNT_W     = 11;

    localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(1024);
    localparam logic [COUNT_W-1:0] CAP_MIN = COUNT_W'(1);

    typedef enum logic [0:0] {
        OP_REG   = 1'b0,
        OP_UNREG = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NEW      = 3'd1,
        STAT_RELEASED = 3'd2,
        STAT_DUP      = 3'd3,
        STAT_UNKNOWN  = 3'd4,
        STAT_NOFREE   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CMD_INC  = 2'd0,
        CMD_SET1 = 2'd1,
        CMD_DEC  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOOKUP = 2'd1,
        S_SCAN   = 2'd2,
        S_DONE   = 2'd3
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [CLIENT_W-1:0] client_id;
    } t_in;

    typedef struct packed {
        logic [GROUP_W-1:0] group_index;
        t_status            status;
        logic [COUNT_W-1:0] group_fill;
    } t_out;

    typedef struct packed {
        logic               valid;
        logic [GROUP_W-1:0] tg;
        logic [COUNT_W-1:0] tg_cnt;
        logic               best_v;
        logic [GROUP_W-1:0] best_idx;
        logic [COUNT_W-1:0] best_cnt;
        logic               free_v;
        logic [GROUP_W-1:0] free_idx;
    } t_scan;

    typedef struct packed {
        logic               en;
        logic [GROUP_W-1:0] idx;
        t_cmd               cmd;
    } t_upd;

endpackage

// File: hdl/ffgp_ram.sv
// ----------------------------------------------------------------------------
// ffgp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffgp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ffgp_cell.sv
// ----------------------------------------------------------------------------
// ffgp_cell
// One group cell. It holds the client count of its group, folds that count
// into the scan token passing through it, and applies update commands that
// address its group.
// ----------------------------------------------------------------------------
module ffgp_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ffgp_pkg::GROUP_W-1:0]    i_idx,
    input  logic [ffgp_pkg::COUNT_W-1:0]    i_cap,
    input  ffgp_pkg::t_scan                 i_tok,
    output ffgp_pkg::t_scan                 o_tok,
    input  ffgp_pkg::t_upd                  i_upd
);
    import ffgp_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_scan              r_tok;
    t_scan              n_tok;

    always_comb begin
        n_tok = i_tok;
        if (r_count == '0) begin
            if (!i_tok.free_v) begin
                n_tok.free_v   = 1'b1;
                n_tok.free_idx = i_idx;
            end
        end else if (r_count < i_cap) begin
            if (!i_tok.best_v || (r_count > i_tok.best_cnt)) begin
                n_tok.best_v   = 1'b1;
                n_tok.best_idx = i_idx;
                n_tok.best_cnt = r_count;
            end
        end
        if (i_tok.tg == i_idx) begin
            n_tok.tg_cnt = r_count;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_upd.en && (i_upd.idx == i_idx)) begin
            case (i_upd.cmd)
                CMD_INC:  n_count = r_count + COUNT_W'(1);
                CMD_SET1: n_count = COUNT_W'(1);
                CMD_DEC:  n_count = r_count - COUNT_W'(1);
                default:  n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: hdl/fullest_first_group_packer.sv
// ----------------------------------------------------------------------------
// fullest_first_group_packer
// Places clients into groups of bounded size, preferring the fullest group
// that still has room, and removes them again on request.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_in_data   (t_in)
//   out      output     o_out_valid / i_out_stall  o_out_data  (t_out)
//   config   input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A result follows its request's transfer through the client table read, the
// walk of the scan token along the row, where each group cell registers it,
// and the commit step. The next request is taken only after the commit, so
// the block never holds more than one request in work. A result held by a
// stalled output keeps the block in its commit step; a new request is taken
// once it commits.
// Reset is synchronous and clears all group counts and client presence bits.
// ----------------------------------------------------------------------------
module fullest_first_group_packer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ffgp_pkg::t_in         i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ffgp_pkg::t_out        o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ffgp_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_cap;
    logic [COUNT_W-1:0]   w_cap;
    logic [NUM_CLIENTS-1:0] r_present;
    t_op                  r_op;
    logic [CLIENT_W-1:0]  r_client;
    logic                 r_pres;
    t_scan                r_fin;
    logic                 r_out_valid;
    t_out                 r_out;

    logic                 w_take;
    logic                 w_launch;
    logic                 w_commit;
    logic [GROUP_W-1:0]   w_rdata;
    t_scan                w_head;
    t_scan                w_tok [NUM_GROUPS+1];
    t_upd                 w_upd;
    t_out                 n_res;
    logic                 w_ram_we;
    logic [GROUP_W-1:0]   w_ram_wdata;
    logic                 w_pres_set;
    logic                 w_pres_clr;
    logic                 w_cfg_we;

    assign w_cfg_we = psel && penable && pwrite && !paddr[2];
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {{(32-COUNT_W){1'b0}}, r_cap};

    always_comb begin
        if (r_cap == '0) begin
            w_cap = CAP_MIN;
        end else if (r_cap > CAP_MAX) begin
            w_cap = CAP_MAX;
        end else begin
            w_cap = r_cap;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_SCAN;
            S_SCAN:   if (w_tok[NUM_GROUPS].valid) n_state = S_DONE;
            S_DONE:   if (!(r_out_valid && i_out_stall)) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_take     = 1'b0;
        w_launch   = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_take     = i_in_valid;
            end
            S_LOOKUP: w_launch = 1'b1;
            S_SCAN:   w_launch = 1'b0;
            S_DONE:   w_commit = !(r_out_valid && i_out_stall);
            default:  o_in_stall = 1'b1;
        endcase
    end

    ffgp_ram #(
        .WIDTH(GROUP_W),
        .DEPTH(NUM_CLIENTS)
    ) u_client_group (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_client),
        .i_wdata (w_ram_wdata),
        .i_raddr (i_in_data.client_id),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_head          = '0;
        w_head.valid    = w_launch;
        w_head.tg       = w_rdata;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_cell
        ffgp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (GROUP_W'(g)),
            .i_cap   (w_cap),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_upd   (w_upd)
        );
    end

    always_comb begin
        n_res       = '0;
        n_res.status = STAT_OK;
        w_upd       = '0;
        w_upd.cmd   = CMD_INC;
        w_ram_we    = 1'b0;
        w_ram_wdata = r_fin.best_idx;
        w_pres_set  = 1'b0;
        w_pres_clr  = 1'b0;
        if (r_op == OP_REG) begin
            if (r_pres) begin
                n_res.group_index = r_fin.tg;
                n_res.status      = STAT_DUP;
                n_res.group_fill  = r_fin.tg_cnt;
            end else if (r_fin.best_v) begin
                n_res.group_index = r_fin.best_idx;
                n_res.status      = STAT_OK;
                n_res.group_fill  = r_fin.best_cnt + COUNT_W'(1);
                w_upd.en          = w_commit;
                w_upd.idx         = r_fin.best_idx;
                w_upd.cmd         = CMD_INC;
                w_ram_we          = w_commit;
                w_ram_wdata       = r_fin.best_idx;
                w_pres_set        = w_commit;
            end else if (r_fin.free_v) begin
                n_res.group_index = r_fin.free_idx;
                n_res.status      = STAT_NEW;
                n_res.group_fill  = COUNT_W'(1);
                w_upd.en          = w_commit;
                w_upd.idx         = r_fin.free_idx;
                w_upd.cmd         = CMD_SET1;
                w_ram_we          = w_commit;
                w_ram_wdata       = r_fin.free_idx;
                w_pres_set        = w_commit;
            end else begin
                n_res.status = STAT_NOFREE;
            end
        end else begin
            if (!r_pres) begin
                n_res.status = STAT_UNKNOWN;
            end else begin
                w_pres_clr        = w_commit;
                n_res.group_index = r_fin.tg;
                if (r_fin.tg_cnt == '0) begin
                    n_res.status = STAT_RELEASED;
                end else begin
                    n_res.group_fill = r_fin.tg_cnt - COUNT_W'(1);
                    n_res.status     = (r_fin.tg_cnt == COUNT_W'(1)) ? STAT_RELEASED
                                                                     : STAT_OK;
                    w_upd.en         = w_commit;
                    w_upd.idx        = r_fin.tg;
                    w_upd.cmd        = CMD_DEC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_MAX;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_we) begin
                r_cap <= pwdata[COUNT_W-1:0];
            end
            if (w_pres_set) begin
                r_present[r_client] <= 1'b1;
            end else if (w_pres_clr) begin
                r_present[r_client] <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op     <= i_in_data.op;
            r_client <= i_in_data.client_id;
            r_pres   <= r_present[i_in_data.client_id];
        end
        if (w_tok[NUM_GROUPS].valid) begin
            r_fin <= w_tok[NUM_GROUPS];
        end
        if (w_commit) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while a previous one is still in work");

    a_new_fill_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == STAT_NEW)) |-> (o_out_data.group_fill == 1))
        else $error("newly opened group does not hold exactly one client");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_data.status == STAT_UNKNOWN) ||
                         (o_out_data.status == STAT_NOFREE)))
        |-> ((o_out_data.group_index == '0) && (o_out_data.group_fill == '0)))
        else $error("error result carries a group or fill");

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> !(r_out_valid && i_out_stall))
        else $error("result committed over a stalled output");
`endif

endmodule
